### src/quaternion_to_euler_angles_assert.svh
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - assertion macros
// Shared property shapes for the converter's concurrent checks.
// ----------------------------------------------------------------------------
`ifndef QUATERNION_TO_EULER_ANGLES_ASSERT_SVH
`define QUATERNION_TO_EULER_ANGLES_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define QEA_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication after a fixed number of cycles, disabled while reset is held.
`define QEA_ASSERT_DELAY(lbl, clk, rst_n, ante, dly, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##(dly) (cons)) \
    else $error(msg);

`endif

### src/qea_pkg.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - package
// Shared widths, case codes, cell data types and the CORDIC arc table.
// ----------------------------------------------------------------------------
package qea_pkg;

  localparam int unsigned IN_BITS_DEF       = 16;
  localparam int unsigned ANGLE_BITS_DEF    = 16;
  localparam int unsigned CORDIC_STAGES_DEF = 16;

  localparam int unsigned Q_W      = 16;  // internal quaternion width (Q1.14)
  localparam int unsigned OP_W     = 34;  // atan2 operand width
  localparam int unsigned CORD_W   = 52;  // CORDIC x/y datapath width
  localparam int unsigned CORD_PRE = 16;  // operand prescale before rotation
  localparam int unsigned ACC_W    = 32;  // binary angle accumulator
  localparam int unsigned RAD_W    = 64;  // square root radicand
  localparam int unsigned ROOT_W   = 32;
  localparam int unsigned REM_W    = 34;
  localparam int unsigned SQRT_N   = 32;  // one root bit per cell

  localparam logic [ACC_W-1:0] ANG_PI          = 32'h8000_0000;
  localparam logic [ACC_W-1:0] ANG_HALF_PI     = 32'h4000_0000;
  localparam logic [ACC_W-1:0] ANG_NEG_HALF_PI = 32'hC000_0000;

  typedef enum logic [1:0] {
    CASE_NORMAL = 2'd0,
    CASE_NORTH  = 2'd1,
    CASE_SOUTH  = 2'd2,
    CASE_ZERO   = 2'd3
  } case_t;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic [ACC_W-1:0]         acc;
    logic                     zero;
  } cord_t;

  typedef struct packed {
    logic [RAD_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    logic [ROOT_W-1:0] root;
  } sqrt_t;

  function automatic logic [ACC_W-1:0] arc_angle(input logic [4:0] idx);
    logic [ACC_W-1:0] a;
    case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

  // Fold into the right half plane, prescale, flag the zero vector.
  function automatic cord_t cord_prep(input logic signed [OP_W-1:0] y,
                                      input logic signed [OP_W-1:0] x);
    logic signed [CORD_W-1:0] xe;
    logic signed [CORD_W-1:0] ye;
    cord_t c;
    xe = CORD_W'(x);
    ye = CORD_W'(y);
    c.zero = (x == '0) && (y == '0);
    if (x < 0) begin
      xe    = -xe;
      ye    = -ye;
      c.acc = ANG_PI;
    end else begin
      c.acc = '0;
    end
    c.x = xe <<< CORD_PRE;
    c.y = ye <<< CORD_PRE;
    return c;
  endfunction

endpackage

### src/qea_sqrt_cell.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - square root cell
// One restoring step of a digit-by-digit integer square root.
// ----------------------------------------------------------------------------
module qea_sqrt_cell (
  input  logic            clk,
  input  qea_pkg::sqrt_t  sin,
  output qea_pkg::sqrt_t  sout
);
  import qea_pkg::*;

  sqrt_t             s_r;
  sqrt_t             s_nxt;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  test;
  logic              ge;

  always_comb begin
    trial = {sin.rem, sin.rad[RAD_W-1 -: 2]};
    test  = (REM_W+2)'({sin.root, 2'b01});
    ge    = (trial >= test);
    s_nxt.rad  = {sin.rad[RAD_W-3:0], 2'b00};
    s_nxt.rem  = ge ? REM_W'(trial - test) : REM_W'(trial);
    s_nxt.root = {sin.root[ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    s_r <= s_nxt;
  end

  assign sout = s_r;

endmodule

### src/qea_cordic_cell.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - CORDIC cell
// One vectoring micro-rotation with its arc accumulated into the angle.
// ----------------------------------------------------------------------------
module qea_cordic_cell #(
  parameter int unsigned STAGE = 0
) (
  input  logic           clk,
  input  qea_pkg::cord_t cin,
  output qea_pkg::cord_t cout
);
  import qea_pkg::*;

  cord_t                    c_r;
  cord_t                    c_nxt;
  logic signed [CORD_W-1:0] sx;
  logic signed [CORD_W-1:0] sy;

  always_comb begin
    sx = cin.x >>> STAGE;
    sy = cin.y >>> STAGE;
    c_nxt.zero = cin.zero;
    // drive y toward zero
    if (!cin.y[CORD_W-1]) begin
      c_nxt.x   = cin.x + sy;
      c_nxt.y   = cin.y - sx;
      c_nxt.acc = cin.acc + arc_angle(5'(STAGE));
    end else begin
      c_nxt.x   = cin.x - sy;
      c_nxt.y   = cin.y + sx;
      c_nxt.acc = cin.acc - arc_angle(5'(STAGE));
    end
  end

  always_ff @(posedge clk) begin
    c_r <= c_nxt;
  end

  assign cout = c_r;

endmodule

### src/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - top level
// Fully pipelined conversion of a Q1.14 quaternion into three binary angles.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive in_quat_x/y/z/w and raise start; the transaction is
//   taken at every rising edge where start is high and busy is low. busy stays
//   low, so a new quaternion may enter in every cycle (one item per cycle).
//   Result channel: out_valid strobes for one cycle with out_angle_x/y/z and
//   out_case_code (normal, north pole, south pole, zero norm). Results leave
//   in the order the transactions came in.
//   Pipeline: the accepting edge loads the scaling register, then come
//   products, sums, partial products, the root radicand, 32 square root
//   cells (one root bit each), one CORDIC entry register, the CORDIC cells
//   and the output register, which holds the strobe and the angles alike.
//   The square root chain feeding the asin rotation sets the depth.
//   Reset: synchronous, active low; it clears the valid line so no stale
//   result strobes out. Payload registers are not reset.
//   Stall: the receiver cannot stall; results are valid for one cycle only.
// ----------------------------------------------------------------------------
`include "quaternion_to_euler_angles_assert.svh"

module quaternion_to_euler_angles #(
  parameter int unsigned IN_BITS       = qea_pkg::IN_BITS_DEF,
  parameter int unsigned ANGLE_BITS    = qea_pkg::ANGLE_BITS_DEF,
  parameter int unsigned CORDIC_STAGES = qea_pkg::CORDIC_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [IN_BITS-1:0]    in_quat_x,
  input  logic signed [IN_BITS-1:0]    in_quat_y,
  input  logic signed [IN_BITS-1:0]    in_quat_z,
  input  logic signed [IN_BITS-1:0]    in_quat_w,
  output logic                         out_valid,
  output logic signed [ANGLE_BITS-1:0] out_angle_x,
  output logic signed [ANGLE_BITS-1:0] out_angle_y,
  output logic signed [ANGLE_BITS-1:0] out_angle_z,
  output logic [1:0]                   out_case_code
);
  import qea_pkg::*;

  localparam int unsigned SH_L   = (IN_BITS < Q_W) ? (Q_W - IN_BITS) : 0;
  localparam int unsigned SH_R   = (IN_BITS > Q_W) ? (IN_BITS - Q_W) : 0;
  localparam int unsigned LINE_N = 2 + SQRT_N;
  localparam int unsigned LAT    = 7 + SQRT_N + CORDIC_STAGES;
  localparam int unsigned P_W    = 2 * Q_W;
  localparam int unsigned S_W    = P_W + 3;
  localparam int unsigned HALF_W = 17;

  // operands and case of one transaction, waiting for its root
  typedef struct packed {
    logic signed [OP_W-1:0] xn;
    logic signed [OP_W-1:0] xd;
    logic signed [OP_W-1:0] yn;
    logic signed [OP_W-1:0] yd;
    logic signed [OP_W-1:0] t2;
    case_t                  cc;
  } pay_t;

  function automatic logic signed [Q_W-1:0] scale_in(input logic signed [IN_BITS-1:0] v);
    logic signed [47:0] e;
    e = 48'(v);
    e = (e <<< SH_L) >>> SH_R;
    return e[Q_W-1:0];
  endfunction

  function automatic logic signed [S_W-1:0] ext(input logic signed [P_W-1:0] v);
    return S_W'(v);
  endfunction

  // round half up from the 32-bit accumulator to the output angle width
  function automatic logic signed [ANGLE_BITS-1:0] to_angle(input logic [ACC_W-1:0] a);
    logic [2*ACC_W-1:0] t;
    t = ({{ACC_W{1'b0}}, a} << ANGLE_BITS) + 64'h8000_0000;
    return t[ACC_W +: ANGLE_BITS];
  endfunction

  logic accept;

  // stage 1: scaled components
  logic                  v1_r;
  logic signed [Q_W-1:0] qx_r, qy_r, qz_r, qw_r;

  // stage 2: products
  logic                  v2_r;
  logic signed [P_W-1:0] p_xx_r, p_yy_r, p_zz_r, p_ww_r;
  logic signed [P_W-1:0] p_xy_r, p_zw_r, p_yw_r, p_xz_r, p_xw_r, p_yz_r;
  logic signed [Q_W-1:0] qx2_r, qw2_r;

  // stage 3: sums and case decision
  logic signed [S_W-1:0] unit, t2, xn, xd, yn, yd, am, ap;
  pay_t                  pay3_nxt;
  pay_t                  pay3_r;
  logic                  v3_r;
  logic [2*HALF_W-2:0]   a3_r, b3_r;

  // stage 4/5: split root radicand product
  logic [2*HALF_W-1:0]   pp_ll_r;
  logic [2*HALF_W-2:0]   pp_lh_r, pp_hl_r;
  logic [2*HALF_W-3:0]   pp_hh_r;
  logic [RAD_W-1:0]      prod_r;

  pay_t                  pay_line_r [LINE_N];
  logic [LINE_N-1:0]     vld_line_r;

  sqrt_t                 sq [SQRT_N+1];

  // CORDIC entry and chains
  cord_t                 ent_x_r, ent_y_r, ent_z_r;
  case_t                 ent_cc_r;
  logic                  ent_v_r;
  cord_t                 cx [CORDIC_STAGES+1];
  cord_t                 cy [CORDIC_STAGES+1];
  cord_t                 cz [CORDIC_STAGES+1];
  case_t                 cc_line_r [CORDIC_STAGES];
  logic [CORDIC_STAGES-1:0] cv_line_r;

  // output
  logic [ACC_W-1:0]      ax, ay, az, dbl;
  logic signed [ANGLE_BITS-1:0] ox, oy, oz;
  case_t                 cc_fin;
  logic                  out_valid_r;
  logic signed [ANGLE_BITS-1:0] out_angle_x_r, out_angle_y_r, out_angle_z_r;
  logic [1:0]            out_case_code_r;

  // every stage advances each cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // ---- stage 1: bring components to Q1.14
  always_ff @(posedge clk) begin
    qx_r <= scale_in(in_quat_x);
    qy_r <= scale_in(in_quat_y);
    qz_r <= scale_in(in_quat_z);
    qw_r <= scale_in(in_quat_w);
  end

  // ---- stage 2: squares and cross terms, one multiplier each
  always_ff @(posedge clk) begin
    p_xx_r <= P_W'(qx_r * qx_r);
    p_yy_r <= P_W'(qy_r * qy_r);
    p_zz_r <= P_W'(qz_r * qz_r);
    p_ww_r <= P_W'(qw_r * qw_r);
    p_xy_r <= P_W'(qx_r * qy_r);
    p_zw_r <= P_W'(qz_r * qw_r);
    p_yw_r <= P_W'(qy_r * qw_r);
    p_xz_r <= P_W'(qx_r * qz_r);
    p_xw_r <= P_W'(qx_r * qw_r);
    p_yz_r <= P_W'(qy_r * qz_r);
    qx2_r  <= qx_r;
    qw2_r  <= qw_r;
  end

  // ---- stage 3: norm, test term, atan2 operands, pole decision
  always_comb begin
    unit = ext(p_xx_r) + ext(p_yy_r) + ext(p_zz_r) + ext(p_ww_r);
    t2   = (ext(p_xy_r) + ext(p_zw_r)) <<< 1;
    xn   = (ext(p_yw_r) - ext(p_xz_r)) <<< 1;
    xd   = ext(p_xx_r) - ext(p_yy_r) - ext(p_zz_r) + ext(p_ww_r);
    yn   = (ext(p_xw_r) - ext(p_yz_r)) <<< 1;
    yd   = -ext(p_xx_r) + ext(p_yy_r) - ext(p_zz_r) + ext(p_ww_r);
    am   = unit - t2;
    ap   = unit + t2;

    if (unit == '0) begin
      pay3_nxt.cc = CASE_ZERO;
    end else if (t2 >= unit) begin
      pay3_nxt.cc = CASE_NORTH;
    end else if (t2 <= -unit) begin
      pay3_nxt.cc = CASE_SOUTH;
    end else begin
      pay3_nxt.cc = CASE_NORMAL;
    end

    pay3_nxt.yn = yn[OP_W-1:0];
    pay3_nxt.yd = yd[OP_W-1:0];
    pay3_nxt.t2 = t2[OP_W-1:0];
    // on a pole the first rotation measures atan2(x, w) instead
    if (pay3_nxt.cc == CASE_NORTH || pay3_nxt.cc == CASE_SOUTH) begin
      pay3_nxt.xn = OP_W'(qx2_r);
      pay3_nxt.xd = OP_W'(qw2_r);
    end else begin
      pay3_nxt.xn = xn[OP_W-1:0];
      pay3_nxt.xd = xd[OP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    pay3_r <= pay3_nxt;
    a3_r   <= am[2*HALF_W-2:0];
    b3_r   <= ap[2*HALF_W-2:0];
  end

  // ---- stage 4: partial products of (unit - t2) * (unit + t2)
  always_ff @(posedge clk) begin
    pp_ll_r <= (2*HALF_W)'(a3_r[HALF_W-1:0] * b3_r[HALF_W-1:0]);
    pp_lh_r <= (2*HALF_W-1)'(a3_r[HALF_W-1:0] * b3_r[2*HALF_W-2:HALF_W]);
    pp_hl_r <= (2*HALF_W-1)'(a3_r[2*HALF_W-2:HALF_W] * b3_r[HALF_W-1:0]);
    pp_hh_r <= (2*HALF_W-2)'(a3_r[2*HALF_W-2:HALF_W] * b3_r[2*HALF_W-2:HALF_W]);
  end

  // ---- stage 5: assemble the radicand (fits 64 bits on the normal path)
  always_ff @(posedge clk) begin
    prod_r <= RAD_W'(pp_ll_r) + (RAD_W'(pp_lh_r) << HALF_W)
            + (RAD_W'(pp_hl_r) << HALF_W) + (RAD_W'(pp_hh_r) << (2*HALF_W));
  end

  // ---- hold operands and valid alongside the root chain
  always_ff @(posedge clk) begin
    pay_line_r[0] <= pay3_r;
    for (int k = 1; k < LINE_N; k++) begin
      pay_line_r[k] <= pay_line_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r       <= 1'b0;
      v2_r       <= 1'b0;
      v3_r       <= 1'b0;
      vld_line_r <= '0;
    end else begin
      v1_r       <= accept;
      v2_r       <= v1_r;
      v3_r       <= v2_r;
      vld_line_r <= {vld_line_r[LINE_N-2:0], v3_r};
    end
  end

  // ---- square root chain, one root bit per cell
  assign sq[0] = '{rad: prod_r, rem: '0, root: '0};

  for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
    qea_sqrt_cell u_cell (
      .clk  (clk),
      .sin  (sq[k]),
      .sout (sq[k+1])
    );
  end

  // ---- CORDIC entry: fold and prescale all three rotations
  always_ff @(posedge clk) begin
    ent_x_r  <= cord_prep(pay_line_r[LINE_N-1].xn, pay_line_r[LINE_N-1].xd);
    ent_y_r  <= cord_prep(pay_line_r[LINE_N-1].yn, pay_line_r[LINE_N-1].yd);
    ent_z_r  <= cord_prep(pay_line_r[LINE_N-1].t2, OP_W'(sq[SQRT_N].root));
    ent_cc_r <= pay_line_r[LINE_N-1].cc;
  end

  assign cx[0] = ent_x_r;
  assign cy[0] = ent_y_r;
  assign cz[0] = ent_z_r;

  for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_cordic
    qea_cordic_cell #(.STAGE(k)) u_cx (.clk(clk), .cin(cx[k]), .cout(cx[k+1]));
    qea_cordic_cell #(.STAGE(k)) u_cy (.clk(clk), .cin(cy[k]), .cout(cy[k+1]));
    qea_cordic_cell #(.STAGE(k)) u_cz (.clk(clk), .cin(cz[k]), .cout(cz[k+1]));
  end

  always_ff @(posedge clk) begin
    cc_line_r[0] <= ent_cc_r;
    for (int k = 1; k < CORDIC_STAGES; k++) begin
      cc_line_r[k] <= cc_line_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_v_r   <= 1'b0;
      cv_line_r <= '0;
    end else begin
      ent_v_r   <= vld_line_r[LINE_N-1];
      cv_line_r <= {cv_line_r[CORDIC_STAGES-2:0], ent_v_r};
    end
  end

  // ---- final angle selection
  always_comb begin
    cc_fin = cc_line_r[CORDIC_STAGES-1];
    // atan2 of the zero vector is zero
    ax  = cx[CORDIC_STAGES].zero ? '0 : cx[CORDIC_STAGES].acc;
    ay  = cy[CORDIC_STAGES].zero ? '0 : cy[CORDIC_STAGES].acc;
    az  = cz[CORDIC_STAGES].zero ? '0 : cz[CORDIC_STAGES].acc;
    dbl = {ax[ACC_W-2:0], 1'b0};
    case (cc_fin)
      CASE_NORMAL: begin
        ox = to_angle(ax);
        oy = to_angle(ay);
        oz = to_angle(az);
      end
      CASE_NORTH: begin
        ox = to_angle(dbl);
        oy = '0;
        oz = to_angle(ANG_HALF_PI);
      end
      CASE_SOUTH: begin
        ox = to_angle(-dbl);
        oy = '0;
        oz = to_angle(ANG_NEG_HALF_PI);
      end
      default: begin
        ox = '0;
        oy = '0;
        oz = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    out_angle_x_r   <= ox;
    out_angle_y_r   <= oy;
    out_angle_z_r   <= oz;
    out_case_code_r <= cc_fin;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cv_line_r[CORDIC_STAGES-1];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_angle_x   = out_angle_x_r;
  assign out_angle_y   = out_angle_y_r;
  assign out_angle_z   = out_angle_z_r;
  assign out_case_code = out_case_code_r;

  // ---- checks
  `QEA_ASSERT_DELAY(a_accept_to_result, clk, rst_n, accept, LAT, out_valid, "accepted transaction produced no result")
  `QEA_ASSERT_IMPL(a_result_from_accept, clk, rst_n, out_valid, $past(accept, LAT), "result strobe without an accepted transaction")
  `QEA_ASSERT_IMPL(a_zero_norm, clk, rst_n, out_valid && (out_case_code == CASE_ZERO), (out_angle_x == '0) && (out_angle_y == '0) && (out_angle_z == '0), "zero-norm result carries nonzero angles")
  `QEA_ASSERT_IMPL(a_pole_angles, clk, rst_n, out_valid && ((out_case_code == CASE_NORTH) || (out_case_code == CASE_SOUTH)), (out_angle_y == '0) && (out_angle_z[ANGLE_BITS-3:0] == '0) && (out_angle_z != '0), "pole result with wrong second or third angle")

endmodule

### sim/quaternion_to_euler_angles_tb.sv
// ----------------------------------------------------------------------------
// Quaternion to Euler angles - testbench
// Drives quaternions into the converter with random gaps, predicts the three
// binary angles and the case code with a bit-exact CORDIC model, and compares
// every result strobe against the oldest prediction in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quaternion_to_euler_angles_tb;
  import qea_pkg::*;

  localparam int LATENCY = 7 + 32 + CORDIC_STAGES_DEF;

  typedef struct packed {
    logic signed [15:0] qx;
    logic signed [15:0] qy;
    logic signed [15:0] qz;
    logic signed [15:0] qw;
  } quat_t;

  typedef struct packed {
    logic [15:0] ax;
    logic [15:0] ay;
    logic [15:0] az;
    case_t       cc;
  } euler_t;

  logic               clk;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic signed [15:0] in_quat_x, in_quat_y, in_quat_z, in_quat_w;
  logic               out_valid;
  logic signed [15:0] out_angle_x, out_angle_y, out_angle_z;
  logic [1:0]         out_case_code;

  quat_t  pending_quats[$];
  euler_t expected_angles[$];
  int     mismatch_count = 0;
  int     send_idle_pct = 9;
  bit     stim_done = 0;
  bit     hold_send = 0;

  quaternion_to_euler_angles dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_quat_x(in_quat_x), .in_quat_y(in_quat_y),
    .in_quat_z(in_quat_z), .in_quat_w(in_quat_w),
    .out_valid(out_valid), .out_angle_x(out_angle_x),
    .out_angle_y(out_angle_y), .out_angle_z(out_angle_z),
    .out_case_code(out_case_code)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Arithmetic shift right that floors, as the hardware does.
  function automatic longint asr(input longint v, input int s);
    return v >>> s;
  endfunction

  // Vectoring CORDIC: binary angle of (x, y) on a 32-bit full circle.
  function automatic logic [31:0] cordic_atan2(input longint y, input longint x);
    logic [31:0] acc;
    longint      sy, sx;
    acc = '0;
    if (x == 0 && y == 0) return '0;
    if (x < 0) begin
      x = -x;
      y = -y;
      acc = ANG_PI;
    end
    x = x * 65536;
    y = y * 65536;
    for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
      sy = asr(y, i);
      sx = asr(x, i);
      if (y >= 0) begin
        x = x + sy;
        y = y - sx;
        acc = acc + arc_angle(i[4:0]);
      end else begin
        x = x - sy;
        y = y + sx;
        acc = acc - arc_angle(i[4:0]);
      end
    end
    return acc;
  endfunction

  // Round half up from the 32-bit accumulator to a 16-bit binary angle.
  function automatic logic [15:0] round_angle(input logic [31:0] a);
    logic [47:0] r;
    r = ({a, 16'h0} + 48'h8000_0000) >> 32;
    return r[15:0];
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return res;
  endfunction

  function automatic euler_t predict_euler(input quat_t q);
    euler_t          e;
    longint          x, y, z, w, sx, sy, sz, sw, norm, t2;
    logic [31:0]     a;
    longint unsigned prod;
    x = q.qx; y = q.qy; z = q.qz; w = q.qw;
    sx = x * x; sy = y * y; sz = z * z; sw = w * w;
    norm = sx + sy + sz + sw;
    t2 = 2 * (x * y + z * w);
    e = '0;
    if (norm == 0) begin
      e.cc = CASE_ZERO;
    end else if (t2 >= norm || t2 <= -norm) begin
      a = cordic_atan2(x, w) * 2;
      if (t2 >= norm) begin
        e.cc = CASE_NORTH;
        e.az = round_angle(ANG_HALF_PI);
      end else begin
        a = -a;
        e.cc = CASE_SOUTH;
        e.az = round_angle(ANG_NEG_HALF_PI);
      end
      e.ax = round_angle(a);
    end else begin
      prod = longint'(norm - t2) * longint'(norm + t2);
      e.ax = round_angle(cordic_atan2(2 * (y * w - x * z), sx - sy - sz + sw));
      e.ay = round_angle(cordic_atan2(2 * (x * w - y * z), -sx + sy - sz + sw));
      e.az = round_angle(cordic_atan2(t2, longint'(floor_root(prod))));
      e.cc = CASE_NORMAL;
    end
    return e;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s got %h expected %h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  // Driver: present the head of the queue; a transaction completes when
  // start is high and busy low at the edge. Predict on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        expected_angles.insert(expected_angles.size(),
                               predict_euler({in_quat_x, in_quat_y,
                                              in_quat_z, in_quat_w}));
        void'(pending_quats.pop_front());
      end
      // Decide next cycle's item from the queue after any pop.
      if (!(start && busy)) begin
        if (pending_quats.size() != 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          start     <= 1'b1;
          in_quat_x <= pending_quats[0].qx;
          in_quat_y <= pending_quats[0].qy;
          in_quat_z <= pending_quats[0].qz;
          in_quat_w <= pending_quats[0].qw;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: a strobe is one transaction; check it against the oldest entry.
  always @(posedge clk) begin
    euler_t want;
    if (rst_n && out_valid) begin
      if (expected_angles.size() == 0) begin
        report_mismatch("unexpected result angle_x", out_angle_x, '0);
      end else begin
        want = expected_angles.pop_front();
        if (out_angle_x !== want.ax) report_mismatch("angle_x", out_angle_x, want.ax);
        if (out_angle_y !== want.ay) report_mismatch("angle_y", out_angle_y, want.ay);
        if (out_angle_z !== want.az) report_mismatch("angle_z", out_angle_z, want.az);
        if (out_case_code !== want.cc)
          report_mismatch("case_code", {14'b0, out_case_code}, {14'b0, want.cc});
      end
    end
  end

  function automatic logic [15:0] rand_comp();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(32)) - 16);
      3: return 16'(int'($urandom_range(32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  // Random quaternion of any norm, sometimes snapped onto a pole.
  function automatic quat_t rand_quat();
    quat_t q;
    int    k;
    logic [15:0] a, b;
    k = $urandom_range(9);
    if (k < 6) begin
      q = {rand_comp(), rand_comp(), rand_comp(), rand_comp()};
    end else if (k < 8) begin
      // Pole: x*y + z*w at half norm when x = y and z = w (sign flips south).
      a = 16'(int'($urandom_range(16384)) - 8192);
      b = 16'(int'($urandom_range(16384)) - 8192);
      if (k == 6) q = {a, a, b, b};
      else        q = {a, -a, b, -b};
      if ($urandom_range(3) == 0) q.qy = q.qy + 16'(int'($urandom_range(2)) - 1);
    end else begin
      q = {16'($urandom_range(16383)) - 16'd8192, 16'($urandom_range(16383)) - 16'd8192,
           16'($urandom_range(16383)) - 16'd8192, 16'($urandom_range(16383)) - 16'd8192};
    end
    return q;
  endfunction

  task automatic wait_drained();
    while (pending_quats.size() != 0 || start || expected_angles.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    quat_t directed[$];
    rst_n = 1'b0;
    start = 1'b0;
    in_quat_x = '0; in_quat_y = '0; in_quat_z = '0; in_quat_w = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero norm, identity, extremes, both poles, each sign quadrant.
    directed = '{
      '{16'sd0, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd0, 16'sd16384},
      '{16'sd0, 16'sd0, 16'sd0, -16'sd16384},
      '{16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF},
      '{16'h8000, 16'h8000, 16'h8000, 16'h8000},
      '{16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF},
      '{16'sd8192, 16'sd8192, 16'sd8192, 16'sd8192},
      '{16'sd8192, -16'sd8192, 16'sd8192, -16'sd8192},
      '{16'sd0, 16'sd0, 16'sd11585, 16'sd11585},
      '{16'sd0, 16'sd0, -16'sd11585, 16'sd11585},
      '{16'sd1, 16'sd1, 16'sd0, 16'sd0},
      '{16'sd1, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd1, 16'sd0, 16'sd0},
      '{16'sd0, 16'sd0, 16'sd1, 16'sd0},
      '{16'sd16384, 16'sd0, 16'sd0, 16'sd0},
      '{-16'sd16384, 16'sd0, 16'sd0, 16'sd0},
      '{16'sd8192, 16'sd8191, 16'sd8192, 16'sd8192},
      '{16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA},
      '{16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555}
    };
    foreach (directed[i]) pending_quats.insert(pending_quats.size(), directed[i]);
    wait_drained();

    // Hold the sender until the pipeline has emptied, then resume.
    hold_send = 1;
    for (int i = 0; i < 20; i++) pending_quats.insert(pending_quats.size(), rand_quat());
    repeat (LATENCY + 5) @(posedge clk);
    hold_send = 0;
    wait_drained();

    // Three phases: light gaps, heavy gaps, no gaps.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 9 : (ph == 1) ? 61 : 0;
      for (int i = 0; i < 400; i++) pending_quats.insert(pending_quats.size(), rand_quat());
      wait_drained();
    end
    repeat (LATENCY + 10) @(posedge clk);
    stim_done = 1;
  end

  initial begin
    wait (stim_done);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Timeout: far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
